@@ rtl/crc64_pkg.sv @@
package crc64_pkg;

    localparam int CRC_W          = 64;
    localparam int BYTES_PER_ITEM = 8;
    localparam int TBL_DEPTH      = 8 * BYTES_PER_ITEM;
    localparam int IDX_W          = $clog2(TBL_DEPTH);
    localparam int SH_W           = $clog2(CRC_W + 1);
    localparam int CNT_W          = 4;
    localparam int ADDR_W         = 4;

    localparam logic [CRC_W-1:0] POLY_RESET = 64'h42F0_E1EB_A9EA_3693;
    localparam logic [CRC_W-1:0] SEED_RESET = 64'h0;

    // register index, taken from paddr[3]
    typedef enum logic
    {
        REG_POLY = 1'b0,
        REG_SEED = 1'b1
    } reg_idx_t;

    // reduction rows: row j holds x^(64+j) mod P
    typedef logic [TBL_DEPTH-1:0][CRC_W-1:0] rtab_t;

    // one msb-first shift of the lfsr
    function automatic logic [CRC_W-1:0] crc_step(
        input logic [CRC_W-1:0] cur,
        input logic [CRC_W-1:0] poly
    );
        crc_step = {cur[CRC_W-2:0], 1'b0} ^ (cur[CRC_W-1] ? poly : '0);
    endfunction

endpackage

@@ rtl/crc64_tbl_build.sv @@
module crc64_tbl_build
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [crc64_pkg::CRC_W-1:0] start_poly,
    input  logic [crc64_pkg::CRC_W-1:0] poly,
    output logic                        busy,
    output crc64_pkg::rtab_t            rtab
);

    logic                        busy_reg;
    logic                        busy_next;
    logic [crc64_pkg::IDX_W-1:0] idx_reg;
    logic [crc64_pkg::IDX_W-1:0] idx_next;
    logic [crc64_pkg::CRC_W-1:0] cur_reg;
    logic [crc64_pkg::CRC_W-1:0] cur_next;
    crc64_pkg::rtab_t            rtab_reg;

    // row 0 is the polynomial itself, each next row one more shift
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        cur_next  = cur_reg;
        priority if (start)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            cur_next  = start_poly;
        end
        else if (busy_reg)
        begin
            cur_next = crc64_pkg::crc_step(cur_reg, poly);
            idx_next = idx_reg + 1'b1;
            if (idx_reg == crc64_pkg::IDX_W'(crc64_pkg::TBL_DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
        end
        else
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            cur_reg  <= crc64_pkg::POLY_RESET;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            cur_reg  <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !start)
        begin
            rtab_reg[idx_reg] <= cur_reg;
        end
    end

    assign busy = busy_reg;
    assign rtab = rtab_reg;

endmodule

@@ rtl/crc64_lane.sv @@
module crc64_lane
(
    input  logic [7:0]                        hi_byte,
    input  logic [7:0][crc64_pkg::CRC_W-1:0]  rows,
    output logic [crc64_pkg::CRC_W-1:0]       part
);

    // gf(2) product of one overflow byte with its eight reduction rows
    always_comb
    begin
        part = '0;
        for (int b = 0; b < 8; b++)
        begin
            part = part ^ (hi_byte[b] ? rows[b] : '0);
        end
    end

endmodule

@@ rtl/crc64_merge.sv @@
module crc64_merge
(
    input  logic [crc64_pkg::CRC_W-1:0]                           low,
    input  logic [crc64_pkg::BYTES_PER_ITEM-1:0][crc64_pkg::CRC_W-1:0] parts,
    output logic [crc64_pkg::CRC_W-1:0]                           crc_out
);

    always_comb
    begin
        crc_out = low;
        for (int k = 0; k < crc64_pkg::BYTES_PER_ITEM; k++)
        begin
            crc_out = crc_out ^ parts[k];
        end
    end

endmodule

@@ rtl/crc64_msb_first_engine.sv @@
// channel  | handshake            | payload
// ---------+----------------------+--------------------------------------
// input    | valid / ready        | data_word[63:0] byte_count[3:0] restart
// result   | crc_valid/crc_ready  | crc_value[63:0]
// config   | apb (psel..pready)   | paddr[3:0] pwdata/prdata[63:0]
//
// one transfer per clock on both sides while ready is high; the result of an
// item shows up in the cycle after its input transfer, from the running crc
// register itself; after reset and after every polynomial write, a build pass
// fills the reduction rows (one row per cycle); ready stays low during it
// a stalled result blocks new input only if it is not taken in that cycle
// all 8 bytes fold combinationally: the critical path is the byte shift plus
// the lane and-xor tree feeding the running crc register
module crc64_msb_first_engine
(
    input  logic                         clk,
    input  logic                         rst_n,
    // message input
    input  logic                         valid,
    output logic                         ready,
    input  logic [63:0]                  data_word,
    input  logic [crc64_pkg::CNT_W-1:0]  byte_count,
    input  logic                         restart,
    // crc result
    output logic                         crc_valid,
    input  logic                         crc_ready,
    output logic [63:0]                  crc_value,
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [crc64_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready
);

    logic [crc64_pkg::CRC_W-1:0] poly_reg;
    logic [crc64_pkg::CRC_W-1:0] poly_next;
    logic [crc64_pkg::CRC_W-1:0] seed_reg;
    logic [crc64_pkg::CRC_W-1:0] seed_next;
    logic [crc64_pkg::CRC_W-1:0] crc_reg;
    logic [crc64_pkg::CRC_W-1:0] crc_next;
    logic                        crc_valid_reg;
    logic                        crc_valid_next;

    logic                        wr_en;
    logic                        poly_wr;
    crc64_pkg::reg_idx_t         reg_sel;
    logic                        tbl_busy;
    crc64_pkg::rtab_t            rtab;
    logic                        in_xfer;

    logic [crc64_pkg::CNT_W-1:0] n_bytes;
    logic [crc64_pkg::SH_W-1:0]  lsh;
    logic [crc64_pkg::SH_W-1:0]  rsh;
    logic [crc64_pkg::CRC_W-1:0] crc_in;
    logic [crc64_pkg::CRC_W-1:0] data_mask;
    logic [crc64_pkg::CRC_W-1:0] t_val;
    logic [crc64_pkg::CRC_W-1:0] low_part;
    logic [crc64_pkg::CRC_W-1:0] hi_part;
    logic [crc64_pkg::CRC_W-1:0] fold_crc;
    logic [crc64_pkg::BYTES_PER_ITEM-1:0][crc64_pkg::CRC_W-1:0] lane_part;

    // register port: written on the access phase; the low three address bits
    // are ignored and paddr[3] picks the register
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = crc64_pkg::reg_idx_t'(paddr[3]);
    assign poly_wr = wr_en && (reg_sel == crc64_pkg::REG_POLY);

    always_comb
    begin
        poly_next = poly_reg;
        seed_next = seed_reg;
        prdata    = '0;
        unique case (reg_sel)
            crc64_pkg::REG_POLY:
            begin
                prdata = poly_reg;
                if (wr_en)
                begin
                    poly_next = pwdata;
                end
            end
            crc64_pkg::REG_SEED:
            begin
                prdata = seed_reg;
                if (wr_en)
                begin
                    seed_next = pwdata;
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    // reduction rows x^(64+j) mod P, rebuilt whenever the polynomial changes
    crc64_tbl_build u_build
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (poly_wr),
        .start_poly (pwdata),
        .poly       (poly_reg),
        .busy       (tbl_busy),
        .rtab       (rtab)
    );

    // input side is free when no row build runs and the result slot is empty or drains this cycle
    assign ready   = !tbl_busy && (!crc_valid_reg || crc_ready);
    assign in_xfer = valid && ready;

    // folding n bytes msb-first is t * x^(8n) mod P, with t the crc xor the
    // counted top bytes; the bits pushed past bit 63 are reduced through the
    // rows, the rest is a plain left shift
    assign n_bytes   = (byte_count > crc64_pkg::CNT_W'(crc64_pkg::BYTES_PER_ITEM))
                       ? crc64_pkg::CNT_W'(crc64_pkg::BYTES_PER_ITEM) : byte_count;
    assign lsh       = crc64_pkg::SH_W'({n_bytes, 3'b000});
    assign rsh       = crc64_pkg::SH_W'(crc64_pkg::CRC_W) - lsh;
    assign crc_in    = restart ? seed_reg : crc_reg;
    assign data_mask = ~({crc64_pkg::CRC_W{1'b1}} >> lsh);
    assign t_val     = crc_in ^ (data_word & data_mask);
    assign low_part  = t_val << lsh;
    // overflow bits, bit j belongs to x^(64+j); zero when no byte counts
    assign hi_part   = t_val >> rsh;

    // one lane per overflow byte
    for (genvar k = 0; k < crc64_pkg::BYTES_PER_ITEM; k++)
    begin : g_lane
        crc64_lane u_lane
        (
            .hi_byte (hi_part[8*k +: 8]),
            .rows    (rtab[8*k +: 8]),
            .part    (lane_part[k])
        );
    end

    crc64_merge u_merge
    (
        .low     (low_part),
        .parts   (lane_part),
        .crc_out (fold_crc)
    );

    // the running crc doubles as the result register
    always_comb
    begin
        crc_next       = crc_reg;
        crc_valid_next = crc_valid_reg;
        if (crc_valid_reg && crc_ready)
        begin
            crc_valid_next = 1'b0;
        end
        if (in_xfer)
        begin
            crc_next       = fold_crc;
            crc_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg      <= crc64_pkg::POLY_RESET;
            seed_reg      <= crc64_pkg::SEED_RESET;
            crc_reg       <= crc64_pkg::SEED_RESET;
            crc_valid_reg <= 1'b0;
        end
        else
        begin
            poly_reg      <= poly_next;
            seed_reg      <= seed_next;
            crc_reg       <= crc_next;
            crc_valid_reg <= crc_valid_next;
        end
    end

    assign crc_valid = crc_valid_reg;
    assign crc_value = crc_reg;

endmodule

@@ rtl/crc64_chk.sv @@
module crc64_chk
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         valid,
    input logic                         ready,
    input logic                         crc_valid,
    input logic                         crc_ready,
    input logic [63:0]                  crc_value,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [crc64_pkg::ADDR_W-1:0] paddr
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        crc_valid && !crc_ready |=> crc_valid && $stable(crc_value))
        else $error("stalled crc result changed");

    // no input taken while a result sits untaken
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        ready |-> (!crc_valid || crc_ready))
        else $error("ready with a blocked result slot");

    // every input transfer gives a result next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        valid && ready |=> crc_valid)
        else $error("accepted item produced no result");

    // no result appears without an input transfer
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        !(valid && ready) && (!crc_valid || crc_ready) |=> !crc_valid)
        else $error("result without an input transfer");

    // a polynomial write starts the row rebuild
    a_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && !paddr[3] |=> !ready)
        else $error("input open during row rebuild");

endmodule

bind crc64_msb_first_engine crc64_chk u_chk (.*);

@@ tb/tb_top.sv @@
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // cycles without any transfer before the run is declared hung
    localparam int STALL_LIMIT     = 2000;
    // long receiver hold-off, long enough to back up the input side
    localparam int LONG_HOLD       = 200;
    localparam int N_DIRECTED      = 24;
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 48;
    // margin after the last result; a result comes in the cycle after its input transfer
    localparam int DRAIN_CYCLES    = 8;
    localparam int MAX_REPORTS     = 10;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // what one row of the directed table does
    typedef enum logic [1:0]
    {
        ROW_ITEM,
        ROW_POLY,
        ROW_SEED
    } row_kind_t;

    // for register rows, data holds the value to write
    typedef struct packed
    {
        row_kind_t                   kind;
        logic [63:0]                 data;
        logic [crc64_pkg::CNT_W-1:0] cnt;
        logic                        rs;
        logic                        lit_use;
        logic [63:0]                 lit_val;
    } step_row_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // message input side
    logic                         valid      = 1'b0;
    logic                         ready;
    logic [63:0]                  data_word  = '0;
    logic [crc64_pkg::CNT_W-1:0]  byte_count = '0;
    logic                         restart    = 1'b0;

    // result side
    logic                         crc_valid;
    logic                         crc_ready  = 1'b0;
    logic [63:0]                  crc_value;

    // register port
    logic                         psel       = 1'b0;
    logic                         penable    = 1'b0;
    logic                         pwrite     = 1'b0;
    logic [crc64_pkg::ADDR_W-1:0] paddr      = '0;
    logic [63:0]                  pwdata     = '0;
    logic [63:0]                  prdata;
    logic                         pready;

    // typed-in expectation travels with the payload of the input transfer
    logic               lit_use    = 1'b0;
    logic [63:0]        lit_val    = '0;

    // shadow of the engine: register copies and the running crc
    logic [63:0]        poly_reg   = crc64_pkg::POLY_RESET;
    logic [63:0]        seed_reg   = crc64_pkg::SEED_RESET;
    logic [63:0]        crc_state  = crc64_pkg::SEED_RESET;

    // crc values still owed by the engine, oldest first
    logic [63:0]        crc_expected [$];

    int                 err_count   = 0;
    int                 idle_cycles = 0;
    logic               hold_off_req = 1'b0;
    logic               quiet_tail   = 1'b0;

    // directed table: extremes, saturation, zero count, register writes between items
    step_row_t directed_rows [N_DIRECTED] = '{
        // right after reset, nothing folded: crc stays zero
        '{ROW_ITEM, 64'h0,                   4'd0,  1'b0, 1'b1, 64'h0},
        // single byte 0x01 from zero folds down to exactly the polynomial,
        // the low bytes are junk and must be ignored
        '{ROW_ITEM, 64'h01A5_5A5A_5A5A_5A5A, 4'd1,  1'b1, 1'b1, crc64_pkg::POLY_RESET},
        '{ROW_ITEM, ALL_ONES,                4'd8,  1'b0, 1'b0, 64'h0},
        // counts above eight saturate
        '{ROW_ITEM, ALL_ONES,                4'd15, 1'b0, 1'b0, 64'h0},
        '{ROW_ITEM, 64'h8000_0000_0000_0001, 4'd9,  1'b1, 1'b0, 64'h0},
        '{ROW_ITEM, 64'h0123_4567_89AB_CDEF, 4'd3,  1'b0, 1'b0, 64'h0},
        // zero count without restart holds the crc
        '{ROW_ITEM, 64'hDEAD_BEEF_0BAD_F00D, 4'd0,  1'b0, 1'b0, 64'h0},
        // zero seed and zero bytes give zero
        '{ROW_ITEM, 64'h0,                   4'd8,  1'b1, 1'b1, 64'h0},
        '{ROW_SEED, ALL_ONES,                4'd0,  1'b0, 1'b0, 64'h0},
        // zero count with restart reports the seed
        '{ROW_ITEM, 64'h5555_5555_5555_5555, 4'd0,  1'b1, 1'b1, ALL_ONES},
        '{ROW_ITEM, 64'hAAAA_AAAA_AAAA_AAAA, 4'd8,  1'b0, 1'b0, 64'h0},
        // zero polynomial: the crc is a plain shift register
        '{ROW_POLY, 64'h0,                   4'd0,  1'b0, 1'b0, 64'h0},
        '{ROW_ITEM, 64'h0,                   4'd4,  1'b1, 1'b1, 64'hFFFF_FFFF_0000_0000},
        '{ROW_ITEM, 64'h0,                   4'd8,  1'b0, 1'b1, 64'h0},
        '{ROW_POLY, ALL_ONES,                4'd0,  1'b0, 1'b0, 64'h0},
        '{ROW_SEED, 64'h0,                   4'd0,  1'b0, 1'b0, 64'h0},
        '{ROW_ITEM, 64'h0100_0000_0000_0000, 4'd1,  1'b1, 1'b1, ALL_ONES},
        '{ROW_ITEM, 64'h0,                   4'd7,  1'b0, 1'b0, 64'h0},
        '{ROW_ITEM, ALL_ONES,                4'd2,  1'b0, 1'b0, 64'h0},
        '{ROW_POLY, crc64_pkg::POLY_RESET,   4'd0,  1'b0, 1'b0, 64'h0},
        '{ROW_SEED, 64'h0123_4567_89AB_CDEF, 4'd0,  1'b0, 1'b0, 64'h0},
        '{ROW_ITEM, 64'h3132_3334_3536_3738, 4'd8,  1'b1, 1'b0, 64'h0},
        '{ROW_ITEM, 64'h3900_0000_0000_0000, 4'd1,  1'b0, 1'b0, 64'h0},
        '{ROW_ITEM, 64'hC3C3_C3C3_C3C3_C3C3, 4'd12, 1'b1, 1'b0, 64'h0}
    };

    crc64_msb_first_engine dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (valid),
        .ready      (ready),
        .data_word  (data_word),
        .byte_count (byte_count),
        .restart    (restart),
        .crc_valid  (crc_valid),
        .crc_ready  (crc_ready),
        .crc_value  (crc_value),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // fold the counted top bytes of a word into a crc, msb first
    function automatic logic [63:0] crc_fold(
        input logic [63:0]                 start,
        input logic [63:0]                 word,
        input logic [crc64_pkg::CNT_W-1:0] cnt,
        input logic [63:0]                 poly
    );
        logic [63:0] c;
        logic [63:0] w;
        int          nbytes;
        int          k;
        int          b;
        c      = start;
        w      = word;
        nbytes = (cnt > crc64_pkg::BYTES_PER_ITEM) ? crc64_pkg::BYTES_PER_ITEM : int'(cnt);
        for (k = 0; k < nbytes; k++)
        begin
            c = c ^ {w[63:56], 56'h0};
            w = w << 8;
            for (b = 0; b < 8; b++)
            begin
                c = c[63] ? ({c[62:0], 1'b0} ^ poly) : {c[62:0], 1'b0};
            end
        end
        return c;
    endfunction

    task automatic report_mismatch(
        input string       what,
        input logic [63:0] want,
        input logic [63:0] got
    );
        err_count++;
        if (err_count <= MAX_REPORTS)
        begin
            $display("mismatch on %s: expected %h, got %h", what, want, got);
        end
    endtask

    // offer one transfer and hold it until the engine takes it
    task automatic send_item(
        input logic [63:0]                 d,
        input logic [crc64_pkg::CNT_W-1:0] c,
        input logic                        r,
        input logic                        lu,
        input logic [63:0]                 lv
    );
        valid      <= 1'b1;
        data_word  <= d;
        byte_count <= c;
        restart    <= r;
        lit_use    <= lu;
        lit_val    <= lv;
        @(posedge clk);
        while (!ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic idle_gap(input int n);
        valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // write a register once the engine has nothing in flight, then read it back
    task automatic write_reg(input crc64_pkg::reg_idx_t idx, input logic [63:0] val);
        valid <= 1'b0;
        @(posedge clk);
        while (crc_expected.size() != 0)
        begin
            @(posedge clk);
        end
        // setup phase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        // access phase, register takes the value at the next edge
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (idx == crc64_pkg::REG_POLY)
        begin
            poly_reg = val;
        end
        else
        begin
            seed_reg = val;
        end
        // readback
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (prdata !== val)
        begin
            report_mismatch(idx == crc64_pkg::REG_POLY ? "polynomial readback"
                                                       : "seed readback",
                            val, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // checker and predictor: outputs sampled before this edge's updates land
    always @(posedge clk)
    begin : crc_monitor
        logic [63:0] nxt;
        if (rst_n)
        begin
            // result transfer first, so a stray result never meets a fresh expectation
            if (crc_valid && crc_ready)
            begin
                if (crc_expected.size() == 0)
                begin
                    report_mismatch("crc_value with nothing outstanding", 64'h0, crc_value);
                end
                else if (crc_value !== crc_expected[0])
                begin
                    report_mismatch("crc_value", crc_expected.pop_front(), crc_value);
                end
                else
                begin
                    void'(crc_expected.pop_front());
                end
            end
            // input transfer: advance the shadow crc
            if (valid && ready)
            begin
                nxt       = crc_fold(restart ? seed_reg : crc_state, data_word,
                                     byte_count, poly_reg);
                crc_state = nxt;
                crc_expected.push_back(lit_use ? lit_val : nxt);
            end
        end
    end

    // watchdog: any transfer, on either channel or the register port, resets it
    always @(posedge clk)
    begin
        if ((valid && ready) || (crc_valid && crc_ready) || (psel && penable))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result sink: random stalls, one long hold-off on request, none in the tail
    initial
    begin : result_sink
        int gap;
        int hold;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                crc_ready <= 1'b0;
                for (hold = 0; hold < LONG_HOLD; hold++)
                begin
                    @(posedge clk);
                end
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                crc_ready <= 1'b0;
                gap = $urandom_range(1, 8);
                repeat (gap) @(posedge clk);
            end
            else
            begin
                crc_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        int                          row;
        int                          phase;
        int                          sent;
        int                          msg_len;
        int                          i;
        logic [crc64_pkg::CNT_W-1:0] cnt;
        logic                        rs;
        logic [63:0]                 pv;
        logic [63:0]                 sv;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (row = 0; row < N_DIRECTED; row++)
        begin
            case (directed_rows[row].kind)
                ROW_POLY:
                begin
                    write_reg(crc64_pkg::REG_POLY, directed_rows[row].data);
                end
                ROW_SEED:
                begin
                    write_reg(crc64_pkg::REG_SEED, directed_rows[row].data);
                end
                default:
                begin
                    if ($urandom_range(0, 2) == 0)
                    begin
                        idle_gap($urandom_range(1, 8));
                    end
                    send_item(directed_rows[row].data, directed_rows[row].cnt,
                              directed_rows[row].rs, directed_rows[row].lit_use,
                              directed_rows[row].lit_val);
                end
            endcase
        end

        // random phases: new settings between phases
        for (phase = 0; phase < N_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    pv = crc64_pkg::POLY_RESET;
                    sv = crc64_pkg::SEED_RESET;
                end
                1:
                begin
                    pv = ALL_ONES;
                    sv = ALL_ONES;
                end
                2:
                begin
                    pv = 64'h1;
                    sv = 64'h0;
                end
                3:
                begin
                    pv = 64'h8000_0000_0000_0000;
                    sv = {$urandom(), $urandom()};
                end
                default:
                begin
                    pv = {$urandom(), $urandom()};
                    sv = {$urandom(), $urandom()};
                end
            endcase
            write_reg(crc64_pkg::REG_POLY, pv);
            write_reg(crc64_pkg::REG_SEED, sv);

            // back up the engine once while the sender keeps offering
            if (phase == 3)
            begin
                hold_off_req = 1'b1;
            end
            if (phase == N_PHASES - 1)
            begin
                quiet_tail = 1'b1;
            end

            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                // messages: restart on the first word, full words, short last word
                msg_len = $urandom_range(1, 10);
                for (i = 0; i < msg_len && sent < ITEMS_PER_PHASE; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        // noise: any count, zero and oversize included
                        cnt = crc64_pkg::CNT_W'($urandom_range(0, 15));
                        rs  = 1'($urandom_range(0, 1));
                    end
                    else
                    begin
                        rs  = (i == 0);
                        cnt = (i == msg_len - 1)
                              ? crc64_pkg::CNT_W'($urandom_range(1, crc64_pkg::BYTES_PER_ITEM))
                              : crc64_pkg::CNT_W'(crc64_pkg::BYTES_PER_ITEM);
                    end
                    if (!quiet_tail && $urandom_range(0, 3) == 0)
                    begin
                        idle_gap($urandom_range(1, 8));
                    end
                    send_item({$urandom(), $urandom()}, cnt, rs, 1'b0, 64'h0);
                    sent++;
                end
            end
        end

        // drain
        valid <= 1'b0;
        @(posedge clk);
        while (crc_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0 && crc_expected.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
